>>> src/sof_length_crc16_frame_deframer_defines.svh
// assertion macros for the frame deframer checker
`ifndef SOF_LENGTH_CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define SOF_LENGTH_CRC16_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, held off during reset
`define SOFDEFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SOFDEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sofdefr_pkg.sv
// types, constants and crc function for the frame deframer
`default_nettype none

package sofdefr_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int BANK_DEPTH  = 2 * MAX_PAYLOAD;
    localparam int ADDR_W      = $clog2(BANK_DEPTH);
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W       = 9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [7:0]  START_BYTE_RST  = 8'd165;
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;

    typedef enum logic [0:0] {
        REG_START_BYTE  = 1'b0,
        REG_GAP_TIMEOUT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_FEED    = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
        logic [7:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic             frame_good;
        logic             crc_mismatch;
        logic             frame_ready;
        logic [7:0]       frame_command;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       read_data;
        logic [2:0]       parser_phase;
    } t_out_item;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/sofdefr_ram.sv
// generic single-write single-read ram with registered read
`default_nettype none

module sofdefr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/sof_length_crc16_frame_deframer.sv
// Start-byte / length / CRC-16 frame deframer. Each request is a feed of one received byte,
// a read of one committed payload byte or a release of the committed frame. Requests may
// follow back to back: each result is registered in an output register when its request
// is taken, and a new request is taken in any cycle in which that register is empty or its
// result is being taken, so a held-off result stalls the input for as long as it is held.
// The payload lives in one 512 x 8 RAM split into a fill bank and a committed bank, written
// by payload feeds and read by read requests through its single registered read port; a good
// CRC swaps the banks. The RAM needs no clearing after reset: only bytes of a committed frame
// are ever read.
`default_nettype none

module sof_length_crc16_frame_deframer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire sofdefr_pkg::t_in_item i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output sofdefr_pkg::t_out_item     o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_addr,
    input  wire logic [15:0]           i_cfg_wdata
);

    localparam int PW = sofdefr_pkg::POS_W;
    localparam int AW = sofdefr_pkg::ADDR_W;
    localparam int LW = sofdefr_pkg::LEN_W;

    logic [7:0]  r_start_byte;
    logic [15:0] r_gap_timeout;

    sofdefr_pkg::t_phase r_phase, n_phase, c_phase;
    logic [7:0]  r_cmd, n_cmd, c_cmd;
    logic [LW-1:0] r_len, n_len, c_len;
    logic [7:0]  r_len_lo, n_len_lo, c_len_lo;
    logic [PW-1:0] r_pos, n_pos, c_pos;
    logic [15:0] r_crc, n_crc, c_crc;
    logic [7:0]  r_crc_lo, n_crc_lo, c_crc_lo;
    logic [31:0] r_last, n_last;
    logic        r_bank, n_bank;
    logic        r_valid, n_valid;
    logic [7:0]  r_ccmd, n_ccmd;
    logic [LW-1:0] r_clen, n_clen;

    logic        accept;
    logic        timed_out;
    logic [15:0] len16;
    logic [PW-1:0] pos_inc;
    logic        good, bad;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_q;

    logic        r_out_valid;
    logic        r_rd_sel;
    sofdefr_pkg::t_out_item r_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // gap check and restart happen before the byte is handled
    assign timed_out = (r_phase != sofdefr_pkg::PH_START)
                       && ((i_in.now_ms - r_last) > {16'h0000, r_gap_timeout});

    always_comb begin
        if (timed_out) begin
            c_phase  = sofdefr_pkg::PH_START;
            c_cmd    = '0;
            c_len    = '0;
            c_len_lo = '0;
            c_pos    = '0;
            c_crc    = sofdefr_pkg::CRC_INIT;
            c_crc_lo = '0;
        end else begin
            c_phase  = r_phase;
            c_cmd    = r_cmd;
            c_len    = r_len;
            c_len_lo = r_len_lo;
            c_pos    = r_pos;
            c_crc    = r_crc;
            c_crc_lo = r_crc_lo;
        end
    end

    assign len16   = {i_in.data_byte, c_len_lo};
    assign pos_inc = c_pos + PW'(1);

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_len_lo  = r_len_lo;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        n_last    = r_last;
        n_bank    = r_bank;
        n_valid   = r_valid;
        n_ccmd    = r_ccmd;
        n_clen    = r_clen;
        good      = 1'b0;
        bad       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(c_pos) + (r_bank ? '0 : AW'(sofdefr_pkg::MAX_PAYLOAD));
        ram_re    = 1'b0;
        ram_raddr = AW'(i_in.read_index) + (r_bank ? AW'(sofdefr_pkg::MAX_PAYLOAD) : '0);
        if (accept) begin
            unique case (sofdefr_pkg::t_op'(i_in.operation))
                sofdefr_pkg::OP_FEED: begin
                    n_phase  = c_phase;
                    n_cmd    = c_cmd;
                    n_len    = c_len;
                    n_len_lo = c_len_lo;
                    n_pos    = c_pos;
                    n_crc    = c_crc;
                    n_crc_lo = c_crc_lo;
                    n_last   = i_in.now_ms;
                    unique case (c_phase)
                        sofdefr_pkg::PH_START: begin
                            if (i_in.data_byte == r_start_byte) begin
                                n_phase = sofdefr_pkg::PH_CMD;
                            end
                        end
                        sofdefr_pkg::PH_CMD: begin
                            n_cmd   = i_in.data_byte;
                            n_crc   = sofdefr_pkg::crc_update(c_crc, i_in.data_byte);
                            n_phase = sofdefr_pkg::PH_LEN_LO;
                        end
                        sofdefr_pkg::PH_LEN_LO: begin
                            n_len_lo = i_in.data_byte;
                            n_crc    = sofdefr_pkg::crc_update(c_crc, i_in.data_byte);
                            n_phase  = sofdefr_pkg::PH_LEN_HI;
                        end
                        sofdefr_pkg::PH_LEN_HI: begin
                            if (len16 > 16'(sofdefr_pkg::MAX_PAYLOAD)) begin
                                n_phase  = sofdefr_pkg::PH_START;
                                n_cmd    = '0;
                                n_len    = '0;
                                n_len_lo = '0;
                                n_pos    = '0;
                                n_crc    = sofdefr_pkg::CRC_INIT;
                                n_crc_lo = '0;
                            end else begin
                                n_crc   = sofdefr_pkg::crc_update(c_crc, i_in.data_byte);
                                n_len   = LW'(len16);
                                n_pos   = '0;
                                n_phase = (len16 == 16'h0000) ? sofdefr_pkg::PH_CRC_LO
                                                              : sofdefr_pkg::PH_PAYLOAD;
                            end
                        end
                        sofdefr_pkg::PH_PAYLOAD: begin
                            ram_we = (c_pos < PW'(sofdefr_pkg::MAX_PAYLOAD));
                            n_crc  = sofdefr_pkg::crc_update(c_crc, i_in.data_byte);
                            n_pos  = pos_inc;
                            if (LW'(pos_inc) >= c_len) begin
                                n_phase = sofdefr_pkg::PH_CRC_LO;
                            end
                        end
                        sofdefr_pkg::PH_CRC_LO: begin
                            n_crc_lo = i_in.data_byte;
                            n_phase  = sofdefr_pkg::PH_CRC_HI;
                        end
                        sofdefr_pkg::PH_CRC_HI: begin
                            if ({i_in.data_byte, c_crc_lo} == c_crc) begin
                                good    = 1'b1;
                                n_bank  = !r_bank;
                                n_valid = 1'b1;
                                n_ccmd  = c_cmd;
                                n_clen  = c_len;
                            end else begin
                                bad = 1'b1;
                            end
                            n_phase  = sofdefr_pkg::PH_START;
                            n_cmd    = '0;
                            n_len    = '0;
                            n_len_lo = '0;
                            n_pos    = '0;
                            n_crc    = sofdefr_pkg::CRC_INIT;
                            n_crc_lo = '0;
                        end
                        default: begin
                            n_phase  = sofdefr_pkg::PH_START;
                            n_cmd    = '0;
                            n_len    = '0;
                            n_len_lo = '0;
                            n_pos    = '0;
                            n_crc    = sofdefr_pkg::CRC_INIT;
                            n_crc_lo = '0;
                        end
                    endcase
                end
                sofdefr_pkg::OP_READ: begin
                    ram_re = r_valid && (LW'(i_in.read_index) < r_clen)
                             && (32'(i_in.read_index) < 32'(sofdefr_pkg::MAX_PAYLOAD));
                end
                sofdefr_pkg::OP_RELEASE: begin
                    n_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= sofdefr_pkg::START_BYTE_RST;
            r_gap_timeout <= sofdefr_pkg::GAP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (sofdefr_pkg::t_reg_idx'(i_cfg_addr))
                sofdefr_pkg::REG_START_BYTE:  r_start_byte  <= i_cfg_wdata[7:0];
                sofdefr_pkg::REG_GAP_TIMEOUT: r_gap_timeout <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sofdefr_pkg::PH_START;
            r_cmd       <= '0;
            r_len       <= '0;
            r_len_lo    <= '0;
            r_pos       <= '0;
            r_crc       <= sofdefr_pkg::CRC_INIT;
            r_crc_lo    <= '0;
            r_last      <= '0;
            r_bank      <= 1'b0;
            r_valid     <= 1'b0;
            r_ccmd      <= '0;
            r_clen      <= '0;
            r_out_valid <= 1'b0;
            r_rd_sel    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_len_lo <= n_len_lo;
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_last   <= n_last;
            r_bank   <= n_bank;
            r_valid  <= n_valid;
            r_ccmd   <= n_ccmd;
            r_clen   <= n_clen;
            if (accept) begin
                r_out_valid <= 1'b1;
                r_rd_sel    <= ram_re;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.frame_good    <= good;
            r_out.crc_mismatch  <= bad;
            r_out.frame_ready   <= n_valid;
            r_out.frame_command <= n_ccmd;
            r_out.frame_length  <= n_clen;
            r_out.read_data     <= '0;
            r_out.parser_phase  <= 3'(n_phase);
        end
    end

    sofdefr_ram #(
        .WIDTH (8),
        .DEPTH (sofdefr_pkg::BANK_DEPTH)
    ) u_bank_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // read data comes straight from the ram register, held while the result waits
    always_comb begin
        o_out           = r_out;
        o_out.read_data = r_rd_sel ? ram_q : 8'h00;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> src/sofdefr_checker.sv
// port-level checker for the frame deframer, bound to the top level
`default_nettype none

`include "sof_length_crc16_frame_deframer_defines.svh"

module sofdefr_checker (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_ready,
    input wire sofdefr_pkg::t_in_item  i_in,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire sofdefr_pkg::t_out_item o_out
);

    logic release_taken;

    assign release_taken = i_in_valid && o_in_ready
                           && (i_in.operation == sofdefr_pkg::OP_RELEASE);

    `SOFDEFR_ASSERT_NOW(a_good_bad_excl, i_clk, i_rst_n, o_out_valid,
        !(o_out.frame_good && o_out.crc_mismatch), "good and mismatch both set")
    `SOFDEFR_ASSERT_NOW(a_good_commits, i_clk, i_rst_n, o_out_valid && o_out.frame_good,
        o_out.frame_ready && (o_out.parser_phase == sofdefr_pkg::PH_START),
        "good frame not committed or parser not restarted")
    `SOFDEFR_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n, release_taken,
        o_out_valid && !o_out.frame_ready, "release did not clear frame_ready")
    `SOFDEFR_ASSERT_NOW(a_read_needs_frame, i_clk, i_rst_n,
        o_out_valid && (o_out.read_data != 8'h00), o_out.frame_ready,
        "read data without a committed frame")
    `SOFDEFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out), "stalled result changed")

endmodule

bind sof_length_crc16_frame_deframer sofdefr_checker u_checker (.*);

`default_nettype wire
